FILE: sv/etf_pkg.sv
// Shared types, constants and helper functions of the escape-time pixel core.
package etf_pkg;

  localparam int FRAC_BITS = 26;
  localparam int COORD_W   = 12;
  localparam int LIMIT_W   = 10;
  localparam int STEP_W    = 31;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  localparam int FRAME_DIM_DEF   = 4096;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Viewport spans in Q6.26; the per-pixel step resets to span / FRAME_DIM, rounded.
  localparam longint REAL_SPAN = 64'd11811160;
  localparam longint IMAG_SPAN = 64'd13421773;

  localparam logic signed [31:0] REAL_MIN_RST  = -32'sd12616466;
  localparam logic signed [31:0] IMAG_MIN_RST  = 32'sd37178311;
  localparam logic [LIMIT_W-1:0] ITER_LIMIT_RST = 10'd200;

  // |z|^2 escape bound: 4.0 in Q6.26
  localparam logic [31:0] ESCAPE_LIMIT = 32'd4 << FRAC_BITS;

  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;

  localparam logic [23:0] DARK_RGB = {8'd16, 8'd16, 8'd16};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_MIN   = 3'd0,
    REG_IMAG_MIN   = 3'd1,
    REG_STEP_REAL  = 3'd2,
    REG_STEP_IMAG  = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_RUN
  } eng_state_t;

  // Complex point c handed from the front end to the iteration engine
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } c_point_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > I32_MAX) begin
      r = 32'sh7fffffff;
    end else if (v < I32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:    rgb = {8'd66,  8'd30,  8'd15};
      4'd1:    rgb = {8'd25,  8'd7,   8'd26};
      4'd2:    rgb = {8'd9,   8'd1,   8'd47};
      4'd3:    rgb = {8'd4,   8'd4,   8'd73};
      4'd4:    rgb = {8'd0,   8'd7,   8'd100};
      4'd5:    rgb = {8'd12,  8'd44,  8'd138};
      4'd6:    rgb = {8'd24,  8'd82,  8'd177};
      4'd7:    rgb = {8'd57,  8'd125, 8'd209};
      4'd8:    rgb = {8'd134, 8'd181, 8'd229};
      4'd9:    rgb = {8'd211, 8'd236, 8'd248};
      4'd10:   rgb = {8'd241, 8'd233, 8'd191};
      4'd11:   rgb = {8'd248, 8'd201, 8'd95};
      4'd12:   rgb = {8'd255, 8'd170, 8'd0};
      4'd13:   rgb = {8'd204, 8'd128, 8'd0};
      4'd14:   rgb = {8'd153, 8'd87,  8'd0};
      default: rgb = {8'd106, 8'd52,  8'd3};
    endcase
    return rgb;
  endfunction

endpackage

FILE: sv/etf_front.sv
// Front end: accepts pixel coordinates and maps them to the complex point c.
module etf_front import etf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COORD_W-1:0]       in_pixel_x,
  input  logic [COORD_W-1:0]       in_pixel_y,
  input  logic signed [31:0]       real_min,
  input  logic signed [31:0]       imag_min,
  input  logic [STEP_W-1:0]        step_real,
  input  logic [STEP_W-1:0]        step_imag,
  input  logic                     q_full,
  output logic                     q_push,
  output c_point_t                 q_data
);

  localparam int PROD_W = COORD_W + STEP_W;

  logic                    v1_r;
  logic                    v2_r;
  logic [PROD_W-1:0]       prod_re_r;
  logic [PROD_W-1:0]       prod_im_r;
  logic [PROD_W-1:0]       prod_re_nxt;
  logic [PROD_W-1:0]       prod_im_nxt;
  logic signed [31:0]      c_re_r;
  logic signed [31:0]      c_im_r;
  logic signed [63:0]      sum_re;
  logic signed [63:0]      sum_im;
  logic signed [32:0]      im_ext;
  logic [32:0]             im_mag;
  logic                    snap;
  logic                    adv;

  // Advance the whole front when the last stage is empty or can drain
  assign adv      = !v2_r || !q_full;
  assign in_ready = adv;
  assign q_push   = v2_r && !q_full;

  assign prod_re_nxt = PROD_W'(in_pixel_x) * PROD_W'(step_real);
  assign prod_im_nxt = PROD_W'(in_pixel_y) * PROD_W'(step_imag);

  assign sum_re = 64'(real_min) + $signed({{(64-PROD_W){1'b0}}, prod_re_r});
  assign sum_im = 64'(imag_min) + $signed({{(64-PROD_W){1'b0}}, prod_im_r});

  // Snap the imaginary part to the axis when it is within half a row
  assign im_ext = 33'(c_im_r);
  assign im_mag = im_ext[32] ? 33'(-im_ext) : 33'(im_ext);
  assign snap   = {im_mag, 1'b0} < {3'd0, step_imag};

  assign q_data.re = c_re_r;
  assign q_data.im = snap ? 32'sd0 : c_im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_re_r <= prod_re_nxt;
      prod_im_r <= prod_im_nxt;
      c_re_r    <= sat32(sum_re);
      c_im_r    <= sat32(sum_im);
    end
  end

endmodule

FILE: sv/etf_queue.sv
// Short FIFO of complex points between the front end and the iteration engine.
module etf_queue import etf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  c_point_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output c_point_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  c_point_t             entries_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CNT_W-1:0]     count_r;
  logic [PTR_W-1:0]     wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: sv/etf_engine.sv
// Iteration engine: runs z = z^2 + c one step per cycle and holds the result.
module etf_engine import etf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [LIMIT_W-1:0]  iter_limit,
  input  logic                q_empty,
  input  c_point_t            q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue,
  output logic [LIMIT_W-1:0]  out_iter_count,
  output logic                out_in_set
);

  eng_state_t           state_r;
  eng_state_t           state_nxt;
  logic signed [31:0]   c_re_r;
  logic signed [31:0]   c_im_r;
  logic signed [31:0]   z_re_r;
  logic signed [31:0]   z_im_r;
  logic [LIMIT_W-1:0]   count_r;
  logic signed [31:0]   z_re_nxt;
  logic signed [31:0]   z_im_nxt;

  logic                 out_valid_r;
  logic [23:0]          out_rgb_r;
  logic [LIMIT_W-1:0]   out_count_r;
  logic                 out_in_set_r;

  logic signed [63:0]   p_xy;
  logic signed [63:0]   p_xx;
  logic signed [63:0]   p_yy;
  logic [30:0]          sq_re;
  logic [30:0]          sq_im;
  logic [31:0]          mag2;
  logic                 escaped;
  logic                 at_limit;
  logic                 done;
  logic                 finish;
  logic                 step;
  logic [23:0]          rgb;

  // Shared multiplier set: two squares and the cross product
  assign p_xy = z_re_r * z_im_r;
  assign p_xx = z_re_r * z_re_r;
  assign p_yy = z_im_r * z_im_r;

  // Floor shift by 26, saturate to Q6.26 max
  assign sq_re = (p_xx[62:57] != '0) ? '1 : p_xx[56:26];
  assign sq_im = (p_yy[62:57] != '0) ? '1 : p_yy[56:26];

  assign mag2     = {1'b0, sq_re} + {1'b0, sq_im};
  assign escaped  = mag2 >= ESCAPE_LIMIT;
  assign at_limit = count_r >= iter_limit;
  assign done     = escaped || at_limit;

  assign z_im_nxt = sat32((p_xy >>> (FRAC_BITS - 1)) + 64'(c_im_r));
  assign z_re_nxt = sat32($signed({33'd0, sq_re}) - $signed({33'd0, sq_im}) + 64'(c_re_r));

  assign rgb = at_limit ? DARK_RGB : palette_rgb(count_r[3:0]);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ENG_IDLE: begin
        if (!q_empty) begin
          state_nxt = ENG_RUN;
        end
      end
      ENG_RUN: begin
        if (done && (!out_valid_r || out_ready)) begin
          state_nxt = ENG_IDLE;
        end
      end
      default: state_nxt = ENG_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    q_pop  = 1'b0;
    finish = 1'b0;
    step   = 1'b0;
    unique case (state_r)
      ENG_IDLE: q_pop = !q_empty;
      ENG_RUN: begin
        finish = done && (!out_valid_r || out_ready);
        step   = !done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      c_re_r  <= q_data.re;
      c_im_r  <= q_data.im;
      z_re_r  <= '0;
      z_im_r  <= '0;
      count_r <= '0;
    end else if (step) begin
      z_re_r  <= z_re_nxt;
      z_im_r  <= z_im_nxt;
      count_r <= count_r + 1'b1;
    end
    if (finish) begin
      out_rgb_r    <= rgb;
      out_count_r  <= count_r;
      out_in_set_r <= at_limit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_rgb_r[23:16];
  assign out_green      = out_rgb_r[15:8];
  assign out_blue       = out_rgb_r[7:0];
  assign out_iter_count = out_count_r;
  assign out_in_set     = out_in_set_r;

endmodule

FILE: sv/escape_time_fractal_pixel_core.sv
// Escape-time pixel core: maps a pixel to c = min + pixel * step (Q6.26) and
// iterates z = z^2 + c until |z|^2 >= 4 or iter_limit, returning the iteration
// count, an in-set flag and a 16-entry palette color. A two-stage front end
// forms c and feeds a QUEUE_DEPTH-entry queue; the engine runs one iteration per
// cycle on one set of three 32x32 multipliers and works on one pixel at a time,
// taking the next from the queue once the last result is registered.
// Configuration writes take effect at once and are meant for idle periods only.
module escape_time_fractal_pixel_core import etf_pkg::*; #(
  parameter int FRAME_DIM   = FRAME_DIM_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_W-1:0]    in_pixel_x,
  input  logic [COORD_W-1:0]    in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic [LIMIT_W-1:0]    out_iter_count,
  output logic                  out_in_set,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  localparam longint STEP_REAL_RST = (REAL_SPAN + FRAME_DIM / 2) / FRAME_DIM;
  localparam longint STEP_IMAG_RST = (IMAG_SPAN + FRAME_DIM / 2) / FRAME_DIM;

  logic signed [31:0]   real_min_r;
  logic signed [31:0]   imag_min_r;
  logic [STEP_W-1:0]    step_real_r;
  logic [STEP_W-1:0]    step_imag_r;
  logic [LIMIT_W-1:0]   iter_limit_r;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  c_point_t             q_wdata;
  c_point_t             q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_min_r   <= REAL_MIN_RST;
      imag_min_r   <= IMAG_MIN_RST;
      step_real_r  <= STEP_W'(STEP_REAL_RST);
      step_imag_r  <= STEP_W'(STEP_IMAG_RST);
      iter_limit_r <= ITER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REAL_MIN:   real_min_r   <= $signed(cfg_wdata);
        REG_IMAG_MIN:   imag_min_r   <= $signed(cfg_wdata);
        REG_STEP_REAL:  step_real_r  <= cfg_wdata[STEP_W-1:0];
        REG_STEP_IMAG:  step_imag_r  <= cfg_wdata[STEP_W-1:0];
        REG_ITER_LIMIT: iter_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  etf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .real_min   (real_min_r),
    .imag_min   (imag_min_r),
    .step_real  (step_real_r),
    .step_imag  (step_imag_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  etf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_rdata)
  );

  etf_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .iter_limit     (iter_limit_r),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_iter_count (out_iter_count),
    .out_in_set     (out_in_set)
  );

endmodule
